FILE: design/lof_pkg.sv
// Shared types, constants and helpers for the largest open square finder.
// Depends on nothing; every other file of the block but lof_ram imports it.
`timescale 1ns / 1ps

package lof_pkg;

    // Width of every score, dimension and coordinate field.
    localparam int FIELD_W = 11;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FIELD_W;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Parameter defaults and the dimension both registers take at reset.
    localparam int                 DEF_MAX_COLS = 1024;
    localparam int                 DEF_MAX_ROWS = 1024;
    localparam logic [FIELD_W-1:0] DIM_RESET    = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_cfg_reg;

    // One cell on its way from the read issue stage to the scoring stage.
    typedef struct packed {
        logic               valid;
        logic               open;
        logic               last;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
    } t_cell;

    typedef struct packed {
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] size;
    } t_result;

    // A dimension of zero counts as one; anything above the limit is clamped.
    function automatic logic [FIELD_W-1:0] eff_dim(input logic [FIELD_W-1:0] v,
                                                   input int limit);
        if (v == '0) begin
            return FIELD_W'(1);
        end
        if (int'(v) > limit) begin
            return FIELD_W'(limit);
        end
        return v;
    endfunction

endpackage

FILE: design/largest_open_square_finder.sv
// Top level of the largest open square finder: configuration registers,
// line buffer RAM and the two pipeline stages. Depends on lof_pkg.
`timescale 1ns / 1ps

// Usage:
// Cells of a grid arrive on the slave stream in row-major order, one cell
// per transaction, with s_axis_tdata[0] set for an open cell and clear for
// an obstacle. After the last cell of each grid the master stream carries
// one transaction with the side of the largest all-open square and its
// bottom-right row and column (the first such square in raster order), or
// size 0 at (grid height, grid width) when the grid has no open cell.
// Throughput is one cell per cycle while no final cell is held (see below).
// A cell is looked up in the line buffer as it is accepted and is scored
// from the cell register of the scan stage; the result register on the
// master side is loaded when the last cell is scored. The line
// buffer never serves a cell the entry that the preceding cell writes in
// the same cycle unless the grid is one column wide, where that entry is
// never used, so no forwarding path is needed.
// Reset and every write to either dimension register restart the grid at
// row 0, column 0 with an empty tracker. A dimension of 0 is taken as 1 and
// one above MAX_COLS or MAX_ROWS is clamped. The line buffer is not cleared:
// the first row of a grid writes every entry before any is used.
// While a result waits on the master side the block keeps accepting cells;
// only the final cell of the next grid and the cells behind it stall until that result is taken.
module largest_open_square_finder #(
    parameter int MAX_COLS = lof_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lof_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [lof_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lof_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Cell stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: [0] cell_open, [7:1] zero.
    input  logic [lof_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: [10:0] best_size, [21:11] best_row, [32:22] best_col, [39:33] zero.
    output logic [lof_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import lof_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    logic [FIELD_W-1:0] r_eff_w, r_eff_h;
    t_cell              w_cell;
    t_result            w_result;
    logic               w_hold;
    logic               w_rd_en, w_wr_en;
    logic [CW-1:0]      w_rd_addr, w_wr_addr;
    logic [FIELD_W-1:0] w_rd_data, w_wr_data;

    // Effective dimensions are stored already clamped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= eff_dim(DIM_RESET, MAX_COLS);
            r_eff_h <= eff_dim(DIM_RESET, MAX_ROWS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_GRID_WIDTH:  r_eff_w <= eff_dim(i_cfg_data, MAX_COLS);
                REG_GRID_HEIGHT: r_eff_h <= eff_dim(i_cfg_data, MAX_ROWS);
                default: ;
            endcase
        end
    end

    lof_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_eff_w   (r_eff_w),
        .i_eff_h   (r_eff_h),
        .i_tvalid  (s_axis_tvalid),
        .i_open    (s_axis_tdata[0]),
        .o_tready  (s_axis_tready),
        .i_hold    (w_hold),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_cell    (w_cell)
    );

    // Line buffer: one score per column, from the row above.
    lof_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    lof_score #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_eff_w   (r_eff_w),
        .i_eff_h   (r_eff_h),
        .i_cell    (w_cell),
        .i_up      (w_rd_data),
        .o_hold    (w_hold),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (w_result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - 3 * FIELD_W)'(0),
                           w_result.col, w_result.row, w_result.size};

`ifndef SYNTHESIS
    // Cells stall only behind a final cell whose result has nowhere to go.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && w_cell.last))
        else $error("cell stream stalled without a blocked result");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cell.valid && w_cell.last && !w_hold) |=> m_axis_tvalid)
        else $error("final cell scored but no result presented");
    a_square_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_result.size != '0) |->
        (w_result.size <= w_result.row + FIELD_W'(1) &&
         w_result.size <= w_result.col + FIELD_W'(1)))
        else $error("reported square extends past the grid origin");
`endif

endmodule

FILE: design/lof_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; the read data holds while no read is issued.
`timescale 1ns / 1ps

module lof_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lof_scan.sv
// Raster position counters, input handshake and line buffer read issue.
// Depends on lof_pkg; feeds one cell per cycle into the scoring stage while i_hold is low.
`timescale 1ns / 1ps

module lof_scan #(
    parameter int MAX_COLS = lof_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lof_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [lof_pkg::FIELD_W-1:0]   i_eff_w,
    input  logic [lof_pkg::FIELD_W-1:0]   i_eff_h,
    input  logic                          i_tvalid,
    input  logic                          i_open,
    output logic                          o_tready,
    input  logic                          i_hold,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_COLS)-1:0]   o_rd_addr,
    output lof_pkg::t_cell                o_cell
);
    import lof_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int EXT = FIELD_W + 1;

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    t_cell          r_cell, n_cell;
    logic           w_accept;
    logic [EXT-1:0] w_col_inc;
    logic [EXT-1:0] w_row_inc;
    logic           w_col_end;
    logic           w_row_end;

    assign o_tready  = !i_hold;
    assign w_accept  = i_tvalid && o_tready;
    assign w_col_inc = EXT'(r_col) + EXT'(1);
    assign w_row_inc = EXT'(r_row) + EXT'(1);
    assign w_col_end = w_col_inc >= EXT'(i_eff_w);
    assign w_row_end = w_row_inc >= EXT'(i_eff_h);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_cell = r_cell;
        if (w_accept) begin
            n_cell.valid = 1'b1;
            n_cell.open  = i_open;
            n_cell.last  = w_col_end && w_row_end;
            n_cell.row   = FIELD_W'(r_row);
            n_cell.col   = FIELD_W'(r_col);
            if (w_col_end) begin
                n_col = '0;
                n_row = w_row_end ? '0 : RW'(w_row_inc);
            end else begin
                n_col = CW'(w_col_inc);
            end
        end else if (!i_hold) begin
            n_cell.valid = 1'b0;
        end
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_cell.valid <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_cell.valid <= n_cell.valid;
        end
        r_cell.open <= n_cell.open;
        r_cell.last <= n_cell.last;
        r_cell.row  <= n_cell.row;
        r_cell.col  <= n_cell.col;
    end

    // The line buffer entry of this column is fetched as the cell enters.
    assign o_rd_en   = w_accept;
    assign o_rd_addr = r_col;
    assign o_cell    = r_cell;

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXT'(r_col) < EXT'(i_eff_w))
        else $error("column counter beyond grid width");
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXT'(r_row) < EXT'(i_eff_h))
        else $error("row counter beyond grid height");
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> (r_col == '0 && r_row == '0))
        else $error("raster position not cleared by a dimension write");
`endif

endmodule

FILE: design/lof_score.sv
// Scoring stage: three-way minimum, line buffer write-back, best-square
// tracking and the result register. Depends on lof_pkg.
`timescale 1ns / 1ps

module lof_score #(
    parameter int MAX_COLS = lof_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lof_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [lof_pkg::FIELD_W-1:0]   i_eff_w,
    input  logic [lof_pkg::FIELD_W-1:0]   i_eff_h,
    input  lof_pkg::t_cell                i_cell,
    input  logic [lof_pkg::FIELD_W-1:0]   i_up,
    output logic                          o_hold,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_COLS)-1:0]   o_wr_addr,
    output logic [lof_pkg::FIELD_W-1:0]   o_wr_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lof_pkg::t_result              o_result
);
    import lof_pkg::*;

    localparam int                 CW       = $clog2(MAX_COLS);
    localparam logic [FIELD_W-1:0] TOP_ROW0 = eff_dim(DIM_RESET, MAX_ROWS);
    localparam logic [FIELD_W-1:0] TOP_COL0 = eff_dim(DIM_RESET, MAX_COLS);

    logic [FIELD_W-1:0] r_left, r_ul;
    logic [FIELD_W-1:0] r_top_size, r_top_row, r_top_col;
    logic               r_valid;
    t_result            r_result;
    logic [FIELD_W-1:0] w_min;
    logic [FIELD_W-1:0] w_score;
    logic               w_adv;
    logic               w_better;

    assign o_hold   = i_cell.valid && i_cell.last && r_valid && !i_ready;
    assign w_adv    = i_cell.valid && !o_hold;
    assign w_better = w_score > r_top_size;

    always_comb begin
        w_min = i_up;
        if (r_left < w_min) begin
            w_min = r_left;
        end
        if (r_ul < w_min) begin
            w_min = r_ul;
        end
        if (!i_cell.open) begin
            w_score = '0;
        end else if (i_cell.row == '0 || i_cell.col == '0) begin
            w_score = FIELD_W'(1);
        end else begin
            w_score = w_min + FIELD_W'(1);
        end
    end

    // Left and up-left are only consumed away from column zero, so they need
    // no clearing at the start of a row.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_left <= w_score;
            r_ul   <= i_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_size <= '0;
            r_top_row  <= TOP_ROW0;
            r_top_col  <= TOP_COL0;
        end else if (i_restart || (w_adv && i_cell.last)) begin
            r_top_size <= '0;
            r_top_row  <= i_eff_h;
            r_top_col  <= i_eff_w;
        end else if (w_adv && w_better) begin
            r_top_size <= w_score;
            r_top_row  <= i_cell.row;
            r_top_col  <= i_cell.col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv && i_cell.last) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (w_adv && i_cell.last) begin
            if (w_better) begin
                r_result.size <= w_score;
                r_result.row  <= i_cell.row;
                r_result.col  <= i_cell.col;
            end else begin
                // With no open cell in the grid the position is the grid size
                // in force now, even right after a dimension write.
                r_result.size <= r_top_size;
                r_result.row  <= (r_top_size == '0) ? i_eff_h : r_top_row;
                r_result.col  <= (r_top_size == '0) ? i_eff_w : r_top_col;
            end
        end
    end

    assign o_wr_en   = w_adv;
    assign o_wr_addr = CW'(i_cell.col);
    assign o_wr_data = w_score;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

endmodule
